>>> src/rqwf_pkg.sv
`timescale 1ns / 1ps

package rqwf_pkg;

	localparam int WINDOW_MAX     = 4096;
	localparam int LEN_BITS       = 24;
	localparam int QUAL_FRAC_BITS = 16;

	localparam int IDX_W      = $clog2(WINDOW_MAX);
	localparam int WIN_W      = IDX_W + 1;
	localparam int WIN_CFG_W  = 13;
	localparam int TOT_W      = LEN_BITS + QUAL_FRAC_BITS;
	localparam int WSUM_W     = IDX_W + QUAL_FRAC_BITS;
	localparam int PCT_W      = 15;
	localparam int SCALE_SH   = QUAL_FRAC_BITS - 8;
	localparam int NUM_W      = ((TOT_W > WSUM_W) ? TOT_W : WSUM_W) + PCT_W;
	localparam int DIV_A      = LEN_BITS + ((SCALE_SH > 0) ? SCALE_SH : 1);
	localparam int DIV_B      = WIN_W + SCALE_SH;
	localparam int DIV_W      = (DIV_A > DIV_B) ? DIV_A : DIV_B;
	localparam int QUO_W      = IDX_W + PCT_W;
	localparam int CNT_W      = $clog2(QUO_W);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = LEN_BITS;

	localparam int PCT_MUL    = 100;
	localparam int LSCORE_MUL = 25600;
	localparam int LEN_OFFSET = 5000;
	localparam int HALF_BASE  = 1 << (QUAL_FRAC_BITS - 1);

	localparam int SH_UP = (QUAL_FRAC_BITS >= 16) ? QUAL_FRAC_BITS - 16 : 0;
	localparam int SH_DN = (QUAL_FRAC_BITS < 16) ? 16 - QUAL_FRAC_BITS : 0;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BASES       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_READ_LENGTH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_READ_LENGTH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_MEAN_QUALITY   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_WINDOW_QUALITY = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ENABLES      = 3'd5;

	// check enable bits
	localparam int CHK_MIN_LEN = 0;
	localparam int CHK_MAX_LEN = 1;
	localparam int CHK_MEAN    = 2;
	localparam int CHK_WINDOW  = 3;

	// correctness probability of Phred 0..47, Q16, saturated
	localparam logic [15:0] QUAL_Q16 [48] = '{
		16'd0,     16'd13479, 16'd24186, 16'd32690, 16'd39446, 16'd44812,
		16'd49074, 16'd52460, 16'd55149, 16'd57286, 16'd58982, 16'd60330,
		16'd61401, 16'd62251, 16'd62927, 16'd63464, 16'd63890, 16'd64228,
		16'd64497, 16'd64711, 16'd64881, 16'd65015, 16'd65122, 16'd65208,
		16'd65275, 16'd65329, 16'd65371, 16'd65405, 16'd65432, 16'd65453,
		16'd65470, 16'd65484, 16'd65495, 16'd65503, 16'd65510, 16'd65515,
		16'd65520, 16'd65523, 16'd65526, 16'd65528, 16'd65529, 16'd65531,
		16'd65532, 16'd65533, 16'd65533, 16'd65534, 16'd65534, 16'd65535
	};

	typedef enum logic [2:0] {
		ST_RUN,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_WIN_GO,
		ST_WIN_WAIT,
		ST_LEN_GO,
		ST_LEN_WAIT,
		ST_EMIT
	} fin_state_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DIV_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic [LEN_BITS-1:0] read_length;
		logic                length_saturated;
		logic [PCT_W-1:0]    mean_quality;
		logic [PCT_W-1:0]    window_quality;
		logic [PCT_W-1:0]    length_score;
		logic                passed;
	} result_t;

	function automatic logic [QUAL_FRAC_BITS-1:0] char_quality(input logic [7:0] c);
		logic [7:0]  q;
		logic [5:0]  qi;
		logic [31:0] v;
		q  = c - 8'd33;
		qi = (q > 8'd47) ? 6'd47 : q[5:0];
		v  = (32'(QUAL_Q16[qi]) << SH_UP) >> SH_DN;
		if (c < 8'd33) begin
			return '0;
		end
		return QUAL_FRAC_BITS'(v);
	endfunction

endpackage

>>> src/rqwf_if.sv
`timescale 1ns / 1ps

interface rqwf_base_if;
	logic       valid;
	logic       ready;
	logic [7:0] quality_char;
	logic       last_base;

	modport source (output valid, quality_char, last_base, input ready);
	modport sink (input valid, quality_char, last_base, output ready);
endinterface

interface rqwf_result_if;
	import rqwf_pkg::*;

	logic                valid;
	logic                ready;
	logic [LEN_BITS-1:0] read_length;
	logic                length_saturated;
	logic [PCT_W-1:0]    mean_quality;
	logic [PCT_W-1:0]    window_quality;
	logic [PCT_W-1:0]    length_score;
	logic                passed;

	modport source (output valid, read_length, length_saturated, mean_quality,
		window_quality, length_score, passed, input ready);
	modport sink (input valid, read_length, length_saturated, mean_quality,
		window_quality, length_score, passed, output ready);
endinterface

interface rqwf_cfg_if;
	import rqwf_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> src/rqwf_div.sv
`timescale 1ns / 1ps

module rqwf_div (
	input  logic               clk,
	input  logic               arst_n,
	input  rqwf_pkg::div_req_t req,
	output rqwf_pkg::div_rsp_t rsp
);
	import rqwf_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] den_q;
	logic [QUO_W-1:0] low_q;

	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             ge;
	logic [DIV_W-1:0] rem_nxt;

	// one quotient bit per cycle, numerator bits shift out as quotient shifts in
	always_comb begin
		trial   = {rem_q, low_q[QUO_W-1]};
		diff    = trial - {1'b0, den_q};
		ge      = trial >= {1'b0, den_q};
		rem_nxt = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= DIV_W'(req.num >> QUO_W);
			low_q <= req.num[QUO_W-1:0];
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			low_q <= {low_q[QUO_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = low_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");

	a_last_step_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cnt_q == '0 && !req.start |=> done_q && !busy_q)
		else $error("divider missed its done pulse");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done longer than one cycle");

endmodule

>>> src/read_quality_window_filter_top.sv
`timescale 1ns / 1ps

// Read quality window filter.
// bases:   one word per base: Phred+33 quality_char and last_base. A base is
//          taken every cycle while a read streams in; ready drops only from
//          its last base until the read's result is loaded for output.
// results: one word per read, sent after the base marked last_base. It holds
//          the read length, saturation flag, mean and minimum-window quality,
//          length score and pass flag, all percentages times 256, floored.
// cfg:     register writes by index, always ready; write only between reads
//          or between bases.
// The end of a read runs three divisions in turn on one shared divider,
// one quotient bit a cycle.
// The window history sits in one memory, written and read at the same
// address in the cycle a base is taken (old value comes out the next cycle).
// Reset clears the per-read state and loads the register defaults; the
// history memory is not cleared. A stalled result waits in the output
// register while the next read already streams in; a second read end waits
// for the register to drain.
module read_quality_window_filter_top (
	input logic               clk,
	input logic               arst_n,
	rqwf_base_if.sink         bases,
	rqwf_result_if.source     results,
	rqwf_cfg_if.sink          cfg
);
	import rqwf_pkg::*;

	// configuration registers
	logic [WIN_CFG_W-1:0] window_bases_q;
	logic [LEN_BITS-1:0]  min_len_q;
	logic [LEN_BITS-1:0]  max_len_q;
	logic [PCT_W-1:0]     min_mean_q;
	logic [PCT_W-1:0]     min_win_q;
	logic [3:0]           check_en_q;

	// per-read state
	logic [IDX_W-1:0]     idx_q;
	logic [LEN_BITS-1:0]  count_q;
	logic                 ovf_q;
	logic [TOT_W-1:0]     total_q;
	logic [WSUM_W-1:0]    cws_q;
	logic [WSUM_W-1:0]    lowest_q;

	// window history memory
	logic [QUAL_FRAC_BITS-1:0] hist_mem [WINDOW_MAX];

	// stage 1
	logic                      v_s1;
	logic                      last_s1;
	logic                      full_s1;
	logic                      chk_s1;
	logic [QUAL_FRAC_BITS-1:0] q_s1;
	logic [QUAL_FRAC_BITS-1:0] rd_s1;

	// end-of-read sequencer
	fin_state_t state_q;
	fin_state_t state_nxt;
	div_req_t   div_req;
	div_rsp_t   div_rsp;
	logic [PCT_W-1:0] mean_q;
	logic [QUO_W-1:0] winq_div_q;
	logic [PCT_W-1:0] lscore_q;

	// output register
	result_t out_q;
	logic    out_valid_q;
	logic    load_out;

	// ------------------------------------------------------------------
	// configuration writes
	// ------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_bases_q <= WIN_CFG_W'(250);
			min_len_q      <= '0;
			max_len_q      <= '1;
			min_mean_q     <= '0;
			min_win_q      <= '0;
			check_en_q     <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_WINDOW_BASES:       window_bases_q <= cfg.data[WIN_CFG_W-1:0];
				CFG_MIN_READ_LENGTH:    min_len_q      <= cfg.data[LEN_BITS-1:0];
				CFG_MAX_READ_LENGTH:    max_len_q      <= cfg.data[LEN_BITS-1:0];
				CFG_MIN_MEAN_QUALITY:   min_mean_q     <= cfg.data[PCT_W-1:0];
				CFG_MIN_WINDOW_QUALITY: min_win_q      <= cfg.data[PCT_W-1:0];
				CFG_CHECK_ENABLES:      check_en_q     <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

	// clamp the window to 1..WINDOW_MAX
	logic [31:0]      wb_ext;
	logic [WIN_W-1:0] w_eff;

	always_comb begin
		wb_ext = 32'(window_bases_q);
		if (wb_ext == 32'd0) begin
			w_eff = WIN_W'(1);
		end else if (wb_ext > 32'(WINDOW_MAX)) begin
			w_eff = WIN_W'(WINDOW_MAX);
		end else begin
			w_eff = WIN_W'(wb_ext);
		end
	end

	// ------------------------------------------------------------------
	// stage 0: take a base, update counters, read and write the history
	// ------------------------------------------------------------------
	logic                      acc;
	logic [QUAL_FRAC_BITS-1:0] q0;
	logic [IDX_W-1:0]          idx_use;
	logic [WIN_W-1:0]          idx_inc;
	logic [IDX_W-1:0]          idx_nxt;
	logic                      full0;
	logic                      count_sat;
	logic [LEN_BITS-1:0]       count_nxt;
	logic                      ovf_nxt;
	logic [TOT_W-1:0]          total_nxt;
	logic                      chk0;

	// hold off new bases while a read end sits in stage 1 or is being finished
	assign bases.ready = (state_q == ST_RUN) && !(v_s1 && last_s1);
	assign acc = bases.valid && bases.ready;

	always_comb begin
		q0        = char_quality(bases.quality_char);
		// wrap the index when the window shrank under it
		idx_use   = ({1'b0, idx_q} >= w_eff) ? '0 : idx_q;
		idx_inc   = {1'b0, idx_use} + WIN_W'(1);
		idx_nxt   = (idx_inc >= w_eff) ? '0 : idx_inc[IDX_W-1:0];
		full0     = ovf_q || (32'(count_q) >= 32'(w_eff));
		count_sat = &count_q;
		// a saturated count stops the total but the window keeps moving
		count_nxt = count_sat ? count_q : count_q + LEN_BITS'(1);
		ovf_nxt   = ovf_q | count_sat;
		total_nxt = count_sat ? total_q : total_q + TOT_W'(q0);
		chk0      = ovf_nxt || (32'(count_nxt) >= 32'(w_eff));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
			total_q <= '0;
		end else if (load_out) begin
			idx_q   <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
			total_q <= '0;
		end else if (acc) begin
			idx_q   <= idx_nxt;
			count_q <= count_nxt;
			ovf_q   <= ovf_nxt;
			total_q <= total_nxt;
		end
	end

	// read-first: the old entry comes out while the new quality goes in
	always_ff @(posedge clk) begin
		if (acc) begin
			hist_mem[idx_use] <= q0;
			rd_s1             <= hist_mem[idx_use];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			q_s1    <= q0;
			full_s1 <= full0;
			chk_s1  <= chk0;
			last_s1 <= bases.last_base;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: slide the window sum and track its minimum
	// ------------------------------------------------------------------
	logic [QUAL_FRAC_BITS-1:0] old_s1;
	logic [WSUM_W-1:0]         cws_sub;
	logic [WSUM_W-1:0]         cws_new;

	always_comb begin
		old_s1  = full_s1 ? rd_s1 : '0;
		// drop the leaving base, floor at zero
		cws_sub = (cws_q >= WSUM_W'(old_s1)) ? cws_q - WSUM_W'(old_s1) : '0;
		cws_new = cws_sub + WSUM_W'(q_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cws_q    <= '0;
			lowest_q <= '1;
		end else if (load_out) begin
			cws_q    <= '0;
			lowest_q <= '1;
		end else if (v_s1) begin
			cws_q <= cws_new;
			if (chk_s1 && cws_new < lowest_q) begin
				lowest_q <= cws_new;
			end
		end
	end

	// ------------------------------------------------------------------
	// end of read: mean, window and length score through one divider
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_RUN:       if (v_s1 && last_s1) state_nxt = ST_MEAN_GO;
			ST_MEAN_GO:   state_nxt = ST_MEAN_WAIT;
			ST_MEAN_WAIT: if (div_rsp.done) state_nxt = ST_WIN_GO;
			ST_WIN_GO:    state_nxt = ST_WIN_WAIT;
			ST_WIN_WAIT:  if (div_rsp.done) state_nxt = ST_LEN_GO;
			ST_LEN_GO:    state_nxt = ST_LEN_WAIT;
			ST_LEN_WAIT:  if (div_rsp.done) state_nxt = ST_EMIT;
			ST_EMIT:      if (load_out) state_nxt = ST_RUN;
			default:      state_nxt = ST_RUN;
		endcase
	end

	// Scale 25600 / 2^F is split as 100 over a denominator shifted by F - 8.
	always_comb begin
		div_req  = '0;
		load_out = 1'b0;
		case (state_q)
			ST_MEAN_GO: begin
				div_req.start = 1'b1;
				div_req.num   = NUM_W'(total_q) * NUM_W'(PCT_MUL);
				div_req.den   = DIV_W'(count_q) << SCALE_SH;
			end
			ST_WIN_GO: begin
				div_req.start = 1'b1;
				div_req.num   = NUM_W'(lowest_q) * NUM_W'(PCT_MUL);
				div_req.den   = DIV_W'(w_eff) << SCALE_SH;
			end
			ST_LEN_GO: begin
				div_req.start = 1'b1;
				div_req.num   = NUM_W'(count_q) * NUM_W'(LSCORE_MUL);
				div_req.den   = DIV_W'(count_q) + DIV_W'(LEN_OFFSET);
			end
			ST_EMIT: begin
				load_out = !out_valid_q || results.ready;
			end
			default: ;
		endcase
	end

	rqwf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// capture each quotient as it lands
	always_ff @(posedge clk) begin
		if (div_rsp.done) begin
			case (state_q)
				ST_MEAN_WAIT: mean_q     <= div_rsp.quo[PCT_W-1:0];
				ST_WIN_WAIT:  winq_div_q <= div_rsp.quo;
				ST_LEN_WAIT:  lscore_q   <= div_rsp.quo[PCT_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// result word
	// ------------------------------------------------------------------
	logic             short_read;
	logic             low_window;
	logic [QUO_W-1:0] winq_full;
	logic             pass;

	always_comb begin
		// a read that fits in one window reports its mean
		short_read = !ovf_q && (32'(count_q) <= 32'(w_eff));
		// under half a base of window sum reports zero
		low_window = lowest_q < WSUM_W'(HALF_BASE);
		if (short_read) begin
			winq_full = QUO_W'(mean_q);
		end else if (low_window) begin
			winq_full = '0;
		end else begin
			winq_full = winq_div_q;
		end
		pass = !((check_en_q[CHK_MIN_LEN] && count_q < min_len_q)
			|| (check_en_q[CHK_MAX_LEN] && (ovf_q || count_q > max_len_q))
			|| (check_en_q[CHK_MEAN] && mean_q < min_mean_q)
			|| (check_en_q[CHK_WINDOW] && winq_full < QUO_W'(min_win_q)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.read_length      <= count_q;
			out_q.length_saturated <= ovf_q;
			out_q.mean_quality     <= mean_q;
			out_q.window_quality   <= winq_full[PCT_W-1:0];
			out_q.length_score     <= lscore_q;
			out_q.passed           <= pass;
		end
	end

	assign results.valid            = out_valid_q;
	assign results.read_length      = out_q.read_length;
	assign results.length_saturated = out_q.length_saturated;
	assign results.mean_quality     = out_q.mean_quality;
	assign results.window_quality   = out_q.window_quality;
	assign results.length_score     = out_q.length_score;
	assign results.passed           = out_q.passed;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	a_last_starts_fin: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && last_s1 |=> state_q == ST_MEAN_GO)
		else $error("read end did not start the finishing sequence");

	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> count_q == '0 && !ovf_q && cws_q == '0 && lowest_q == '1)
		else $error("per-read state not cleared after result load");

	a_lowest_falls: assert property (@(posedge clk) disable iff (!arst_n)
		!load_out |=> lowest_q <= $past(lowest_q))
		else $error("minimum window sum rose within a read");

endmodule
